// File: design/wgeo_pkg.sv
// ----------------------------------------------------------------------------
// wgeo_pkg
// Shared types and constants of the window geometry ease tween.
// ----------------------------------------------------------------------------
package wgeo_pkg;

    localparam int WIN_W           = 3;
    localparam int GEO_W           = 16;
    localparam int LANES           = 4;
    localparam int PHASE_W         = 17;
    localparam int STEP_W          = 17;
    localparam int K_W             = 16;
    localparam int SLOTS_MAX       = 8;
    localparam int DEFAULT_WINDOWS = 8;
    localparam int QDEPTH          = 2;

    localparam int FUNC_W    = 2;
    localparam int S_TDATA_W = ((WIN_W + 2 * LANES * GEO_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WIN_W + LANES * GEO_W + 7) / 8) * 8;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_PHASE_STEP = 1'b0;

    localparam logic [FUNC_W-1:0] FN_RESIZE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CANCEL = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = 17'h10000;
    localparam logic [STEP_W-1:0]  STEP_RESET = 17'd4096;

    typedef enum logic [1:0] {
        KIND_RESIZE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_CANCEL = 2'd2
    } kind_t;

    // lane 0 x, 1 y, 2 width, 3 height
    typedef logic [LANES-1:0][GEO_W-1:0] geo_t;

    typedef struct packed {
        kind_t            kind;
        logic [WIN_W-1:0] window;
        geo_t             req;
        geo_t             prev;
    } cmd_t;

    typedef struct packed {
        logic [$clog2(QDEPTH+1)-1:0] count;
        logic                        full;
    } front_status_t;

    typedef struct packed {
        logic idle;
        logic ticking;
    } back_status_t;

    // x and y lanes are signed, width and height are not
    function automatic logic [GEO_W:0] geo_ext(input logic [GEO_W-1:0] v, input logic sgn);
        return {sgn & v[GEO_W-1], v};
    endfunction

endpackage

// File: design/wgeo_mul.sv
// ----------------------------------------------------------------------------
// wgeo_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module wgeo_mul (
    input  logic                         aclk,
    input  logic [wgeo_pkg::MUL_A_W-1:0] a,
    input  logic [wgeo_pkg::MUL_B_W-1:0] b,
    output logic [wgeo_pkg::MUL_P_W-1:0] prod
);
    import wgeo_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

// File: design/wgeo_front.sv
// ----------------------------------------------------------------------------
// wgeo_front
// Takes input items, sorts out resize, tick and cancel, drops what does
// nothing, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module wgeo_front #(
    parameter int WINDOWS = wgeo_pkg::DEFAULT_WINDOWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wgeo_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [wgeo_pkg::FUNC_W-1:0]    s_tuser,
    output logic                           cmd_valid,
    output wgeo_pkg::cmd_t                 cmd,
    input  logic                           cmd_pop,
    output wgeo_pkg::front_status_t        status
);
    import wgeo_pkg::*;

    localparam int SLOTS = (WINDOWS < SLOTS_MAX) ? WINDOWS : SLOTS_MAX;
    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             q_mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    cmd_t             new_cmd;
    logic [WIN_W-1:0] win;
    logic             win_ok;
    logic             keep;
    logic             push;

    always_comb begin
        win            = s_tdata[WIN_W-1:0];
        win_ok         = ({1'b0, win} < (WIN_W + 1)'(SLOTS));
        new_cmd.window = win;
        new_cmd.req    = s_tdata[WIN_W +: LANES * GEO_W];
        new_cmd.prev   = s_tdata[WIN_W + LANES * GEO_W +: LANES * GEO_W];
        case (s_tuser)
            FN_RESIZE: begin
                keep         = win_ok;
                new_cmd.kind = KIND_RESIZE;
            end
            FN_TICK: begin
                keep         = 1'b1;
                new_cmd.kind = KIND_TICK;
            end
            FN_CANCEL: begin
                keep         = win_ok;
                new_cmd.kind = KIND_CANCEL;
            end
            default: begin
                keep         = 1'b0;
                new_cmd.kind = KIND_TICK;
            end
        endcase
    end

    assign s_tready = (count_reg != CNT_W'(QDEPTH));
    assign push     = s_tvalid & s_tready & keep;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    assign cmd_valid    = (count_reg != '0);
    assign cmd          = q_mem[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = ~s_tready;

endmodule

// File: design/wgeo_back.sv
// ----------------------------------------------------------------------------
// wgeo_back
// Slot state and the sequencer that carries out resize, cancel and tick,
// with one shared multiplier and the result register.
// ----------------------------------------------------------------------------
module wgeo_back #(
    parameter int WINDOWS = wgeo_pkg::DEFAULT_WINDOWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [wgeo_pkg::STEP_W-1:0]    phase_step,
    input  logic                           cmd_valid,
    input  wgeo_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wgeo_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast,
    output wgeo_pkg::back_status_t         status
);
    import wgeo_pkg::*;

    localparam int SLOTS  = (WINDOWS < SLOTS_MAX) ? WINDOWS : SLOTS_MAX;
    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SINGLE = 7'b0000010,
        ST_SLOT   = 7'b0000100,
        ST_CUBE   = 7'b0001000,
        ST_KCALC  = 7'b0010000,
        ST_SCALE  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    // slot storage
    logic [SLOTS-1:0]   active_reg;
    geo_t               cur_mem   [SLOTS];
    geo_t               tgt_mem   [SLOTS];
    logic [PHASE_W-1:0] phase_mem [SLOTS];

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [SIDX_W-1:0]   idx_reg, idx_next;
    logic [GEO_W-1:0]    u_reg, u_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [2:0]          lane_reg, lane_next;
    logic                neg_reg, neg_next;
    geo_t                new_reg, new_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [WIN_W-1:0]    out_win_reg;
    geo_t                out_geo_reg;
    logic                out_final_reg;
    logic                out_last_reg;

    // read side
    geo_t                cur_rd, tgt_rd;
    logic [PHASE_W-1:0]  phase_rd;
    logic                act_rd;
    logic [SLOTS-1:0]    above_mask;
    logic                more;

    // write side
    logic                cur_we, tgt_we, phase_we, act_set, act_clr;
    geo_t                cur_wd;
    logic [PHASE_W-1:0]  phase_wd;

    // emit
    logic                out_free, emit;
    geo_t                emit_geo;
    logic                emit_final, emit_last;

    // datapath
    logic [PHASE_W:0]    p_sum;
    logic                landed;
    logic [PHASE_W-1:0]  p_new;
    logic [PHASE_W-1:0]  u_full;
    logic [K_W-1:0]      k_calc;
    logic [1:0]          iss_lane, cap_lane;
    logic [GEO_W:0]      diff, mag, cap_step, cap_val;
    logic                same_tgt, snap;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  prod;

    wgeo_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cur_rd   = cur_mem[idx_reg];
    assign tgt_rd   = tgt_mem[idx_reg];
    assign phase_rd = phase_mem[idx_reg];
    assign act_rd   = active_reg[idx_reg];

    // last result of a tick: no active slot above this one
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            above_mask[j] = (SIDX_W'(j) > idx_reg);
        end
        more = |(active_reg & above_mask);
    end

    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb begin
        p_sum    = {1'b0, phase_rd} + {1'b0, phase_step};
        landed   = (p_sum >= {1'b0, PHASE_ONE});
        p_new    = landed ? PHASE_ONE : p_sum[PHASE_W-1:0];
        u_full   = PHASE_ONE - p_new;
        // k = 1 - (1-t)^3, saturated below 1.0
        k_calc   = (prod[47:32] == '0) ? '1 : K_W'({1'b0, PHASE_ONE} - {2'b0, prod[47:32]});
        iss_lane = lane_reg[1:0];
        cap_lane = 2'(lane_reg - 3'd1);
        diff     = geo_ext(tgt_rd[iss_lane], ~iss_lane[1])
                 - geo_ext(cur_rd[iss_lane], ~iss_lane[1]);
        mag      = diff[GEO_W] ? ((GEO_W + 1)'(0) - diff) : diff;
        cap_step = {1'b0, prod[31:16]};
        cap_val  = geo_ext(cur_rd[cap_lane], ~cap_lane[1])
                 + (neg_reg ? ((GEO_W + 1)'(0) - cap_step) : cap_step);
        same_tgt = (tgt_rd == cmd_reg.req);
        snap     = ~act_rd && (cmd_reg.req[2] == cmd_reg.prev[2])
                           && (cmd_reg.req[3] == cmd_reg.prev[3]);
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        u_next     = u_reg;
        k_next     = k_reg;
        lane_next  = lane_reg;
        neg_next   = neg_reg;
        new_next   = new_reg;
        cmd_pop    = 1'b0;
        cur_we     = 1'b0;
        tgt_we     = 1'b0;
        phase_we   = 1'b0;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        cur_wd     = new_reg;
        phase_wd   = p_new;
        emit       = 1'b0;
        emit_geo   = new_reg;
        emit_final = 1'b0;
        emit_last  = ~more;
        mul_a      = {{(MUL_A_W - GEO_W){1'b0}}, mag[GEO_W-1:0]};
        mul_b      = k_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    if (cmd.kind == KIND_TICK) begin
                        idx_next   = '0;
                        state_next = ST_SLOT;
                    end else begin
                        idx_next   = cmd.window[SIDX_W-1:0];
                        state_next = ST_SINGLE;
                    end
                end
            end

            ST_SINGLE: begin
                case (cmd_reg.kind)
                    KIND_CANCEL: begin
                        act_clr    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    KIND_RESIZE: begin
                        if (act_rd && same_tgt) begin
                            state_next = ST_IDLE;
                        end else if (out_free) begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            state_next = ST_IDLE;
                            if (snap) begin
                                emit_geo   = cmd_reg.req;
                                emit_final = 1'b1;
                            end else begin
                                emit_geo = act_rd ? cur_rd : cmd_reg.prev;
                                cur_we   = ~act_rd;
                                cur_wd   = cmd_reg.prev;
                                tgt_we   = 1'b1;
                                phase_we = 1'b1;
                                phase_wd = '0;
                                act_set  = 1'b1;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SLOT: begin
                if (!act_rd) begin
                    state_next = (idx_reg == SIDX_W'(SLOTS - 1)) ? ST_IDLE : ST_SLOT;
                    idx_next   = idx_reg + 1'b1;
                end else if (landed) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_geo   = tgt_rd;
                        emit_final = 1'b1;
                        cur_we     = 1'b1;
                        cur_wd     = tgt_rd;
                        phase_we   = 1'b1;
                        act_clr    = 1'b1;
                        state_next = (idx_reg == SIDX_W'(SLOTS - 1)) ? ST_IDLE : ST_SLOT;
                        idx_next   = idx_reg + 1'b1;
                    end
                end else begin
                    phase_we = 1'b1;
                    if (u_full[PHASE_W-1]) begin
                        // phase still zero: k is zero
                        k_next     = '0;
                        lane_next  = '0;
                        state_next = ST_SCALE;
                    end else begin
                        mul_a      = {{(MUL_A_W - GEO_W){1'b0}}, u_full[GEO_W-1:0]};
                        mul_b      = u_full[GEO_W-1:0];
                        u_next     = u_full[GEO_W-1:0];
                        state_next = ST_CUBE;
                    end
                end
            end

            ST_CUBE: begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = u_reg;
                state_next = ST_KCALC;
            end

            ST_KCALC: begin
                k_next     = k_calc;
                lane_next  = '0;
                state_next = ST_SCALE;
            end

            ST_SCALE: begin
                // issue lane n while the product of lane n-1 comes back
                neg_next  = diff[GEO_W];
                lane_next = lane_reg + 1'b1;
                if (lane_reg != '0) begin
                    new_next[cap_lane] = cap_val[GEO_W-1:0];
                end
                if (lane_reg == 3'(LANES)) begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    cur_we     = 1'b1;
                    state_next = (idx_reg == SIDX_W'(SLOTS - 1)) ? ST_IDLE : ST_SLOT;
                    idx_next   = idx_reg + 1'b1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            active_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (act_set) begin
                active_reg[idx_reg] <= 1'b1;
            end else if (act_clr) begin
                active_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        u_reg    <= u_next;
        k_reg    <= k_next;
        lane_reg <= lane_next;
        neg_reg  <= neg_next;
        new_reg  <= new_next;
        if (cur_we) begin
            cur_mem[idx_reg] <= cur_wd;
        end
        if (tgt_we) begin
            tgt_mem[idx_reg] <= cmd_reg.req;
        end
        if (phase_we) begin
            phase_mem[idx_reg] <= phase_wd;
        end
        if (emit) begin
            out_win_reg   <= WIN_W'(idx_reg);
            out_geo_reg   <= emit_geo;
            out_final_reg <= emit_final;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = {{(M_TDATA_W - WIN_W - LANES * GEO_W){1'b0}}, out_geo_reg, out_win_reg};
    assign m_tuser        = out_final_reg;
    assign m_tlast        = out_last_reg;
    assign status.idle    = (state_reg == ST_IDLE);
    assign status.ticking = (state_reg != ST_IDLE) && (cmd_reg.kind == KIND_TICK);

endmodule

// File: design/window_geometry_ease_tween.sv
// ----------------------------------------------------------------------------
// window_geometry_ease_tween
// Ease-out cubic tween of window geometry, one animation slot per window.
//
//   port group   dir   payload                                      handshake
//   s_*          in    tuser func; tdata window, req_*, prev_*      tvalid/tready
//   m_*          out   tuser final_res; tlast last; tdata geometry  tvalid/tready
//   p*           in    phase_step at byte address 0                 APB, pready high
//
// Resize and cancel: a queue pop, then one slot access in the back end.
// Tick: a pop, a step per slot, and for a moving slot cube, k, four-lane
// scaling and emit (no cube or k at phase zero); one shared 32x16 multiplier.
// Synchronous reset clears the slot flags at once; no clearing pass.
// A two-entry command queue takes items while the back end works; a result
// waits in the output register and stalls the back end until taken.
// ----------------------------------------------------------------------------
module window_geometry_ease_tween #(
    parameter int WINDOWS = wgeo_pkg::DEFAULT_WINDOWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] window, [18:3] req_x, [34:19] req_y, [50:35] req_w, [66:51] req_h,
    // [82:67] prev_x, [98:83] prev_y, [114:99] prev_w, [130:115] prev_h
    input  logic [wgeo_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [wgeo_pkg::FUNC_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] out_window, [18:3] geo_x, [34:19] geo_y, [50:35] geo_w, [66:51] geo_h
    output logic [wgeo_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] final_res
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wgeo_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wgeo_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wgeo_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import wgeo_pkg::*;

    logic [STEP_W-1:0]       phase_step_reg, phase_step_next;
    logic [APB_ADDR_W-3:0]   cfg_sel;
    logic                    cfg_wr;

    logic                    cmd_valid;
    cmd_t                    cmd;
    logic                    cmd_pop;
    front_status_t           front_st;
    back_status_t            back_st;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        phase_step_next = phase_step_reg;
        if (cfg_wr && (cfg_sel == REG_PHASE_STEP)) begin
            phase_step_next = pwdata[STEP_W-1:0];
        end
        prdata = (cfg_sel == REG_PHASE_STEP)
               ? {{(APB_DATA_W - STEP_W){1'b0}}, phase_step_reg} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= STEP_RESET;
        end else begin
            phase_step_reg <= phase_step_next;
        end
    end

    wgeo_front #(
        .WINDOWS (WINDOWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .status    (front_st)
    );

    wgeo_back #(
        .WINDOWS (WINDOWS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .phase_step (phase_step_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .status     (back_st)
    );

    // queue never holds more than its depth, and full matches its count
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_st.count <= QDEPTH) && (front_st.full == (front_st.count == QDEPTH)))
        else $error("command queue count out of range");

    // back end takes a command only when idle and one is queued
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (back_st.idle && cmd_valid))
        else $error("command popped while back end busy or queue empty");

    // a result appears only after the back end was working on an item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(back_st.idle))
        else $error("result raised by an idle back end");

    // only a tick gives more than one result per item
    a_nonlast_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> back_st.ticking)
        else $error("non-last result outside a tick");

endmodule
